[sv/assert_macros.svh]
// Assertion macros used by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/qmm_pkg.sv]
// Types, key codes and helpers for the quadrotor manual mode mixer.
package qmm_pkg;

  typedef enum logic [2:0] {
    MODE_SAFE   = 3'd0,
    MODE_PANIC  = 3'd1,
    MODE_MANUAL = 3'd2,
    MODE_CALIB  = 3'd3,
    MODE_YAW    = 3'd4,
    MODE_FULL   = 3'd5
  } mode_t;

  typedef enum logic [0:0] {
    CMD_KEY   = 1'b0,
    CMD_STICK = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_EXIT_KEY   = 1'b0,
    CFG_SWITCH_KEY = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] EXIT_KEY_RST   = 8'd27;
  localparam logic [7:0] SWITCH_KEY_RST = 8'd50;

  localparam logic [7:0] KEY_MODE_LO    = 8'h30;
  localparam logic [7:0] KEY_MODE_HI    = 8'h35;
  localparam logic [7:0] KEY_LIFT_UP    = 8'h61;
  localparam logic [7:0] KEY_LIFT_DN    = 8'h7A;
  localparam logic [7:0] KEY_ROLL_UP    = 8'h43;
  localparam logic [7:0] KEY_ROLL_DN    = 8'h44;
  localparam logic [7:0] KEY_PITCH_DN   = 8'h41;
  localparam logic [7:0] KEY_PITCH_UP   = 8'h42;
  localparam logic [7:0] KEY_YAW_UP     = 8'h77;
  localparam logic [7:0] KEY_YAW_DN     = 8'h71;

  localparam logic signed [7:0] TRIM_MAX  = 8'sd127;
  localparam logic signed [7:0] TRIM_MIN  = -8'sd127;
  localparam logic signed [9:0] RP_MAX    = 10'sd64;
  localparam logic signed [9:0] RP_MIN    = -10'sd64;
  localparam logic signed [9:0] LIFT_MAX  = 10'sd128;
  localparam logic signed [9:0] LIFT_MIN  = 10'sd0;

  // Step a trim by one, saturating at the trim limits.
  function automatic logic signed [7:0] trim_up(input logic signed [7:0] t);
    return (t == TRIM_MAX) ? t : t + 8'sd1;
  endfunction

  function automatic logic signed [7:0] trim_dn(input logic signed [7:0] t);
    return (t == TRIM_MIN) ? t : t - 8'sd1;
  endfunction

  // Divide by four, truncating toward zero.
  function automatic logic signed [8:0] div4_trunc(input logic signed [11:0] v);
    logic signed [11:0] adj;
    adj = v + (v[11] ? 12'sd3 : 12'sd0);
    return adj[10:2];
  endfunction

endpackage

[sv/quadrotor_manual_mode_mixer.sv]
// Quadrotor manual mode mixer: key/stick messages in, flight mode and motor mix out.
//
// Input channel (in_*): one message per word, valid/ready. in_cmd selects a
// key press (in_key_code) or four joystick bytes (in_stick_*).
// Output channel (out_*): exactly one word per accepted message, carrying the
// flight mode, the exit flag and the four motor values after that message.
// Configuration (cfg_*): cfg_we writes cfg_wdata into the exit key code
// (index 0) or the switch key code (index 1); write only while idle.
// Path: a word is registered in the input stage, processed by one level of
// add/clamp/mix logic and registered in the output stage that drives out_*.
// Throughput: one word per cycle unless stalled; the state update and result
// register load happen at the same edge, so the next word sees the new state.
// Stall: when out_ready is low the result holds, one more word waits in the
// input register, and in_ready drops only once both are full.
// Reset (rst_n low, synchronous): both stages empty, safe mode, exit flag,
// trims, joystick values, combined axes and motors cleared, key codes back
// to their defaults (27 and 50).
`include "assert_macros.svh"

module quadrotor_manual_mode_mixer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_key_code,
  input  logic [7:0]        in_stick_roll,
  input  logic [7:0]        in_stick_pitch,
  input  logic [7:0]        in_stick_yaw,
  input  logic [7:0]        in_stick_lift,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_flight_mode,
  output logic              out_exit_done,
  output logic signed [8:0] out_motor_one,
  output logic signed [8:0] out_motor_two,
  output logic signed [8:0] out_motor_three,
  output logic signed [8:0] out_motor_four
);

  // configuration
  logic [7:0] exit_key_r, switch_key_r;

  // input stage
  logic       s1_v_r;
  logic       s1_cmd_r;
  logic [7:0] s1_key_r, s1_roll_r, s1_pitch_r, s1_yaw_r, s1_lift_r;

  // output stage
  logic              out_v_r;
  qmm_pkg::mode_t    out_mode_r;
  logic              out_exit_r;
  logic signed [8:0] out_m1_r, out_m2_r, out_m3_r, out_m4_r;

  // block state
  qmm_pkg::mode_t    mode_r, mode_nxt;
  logic              exit_r, exit_nxt;
  logic signed [7:0] tr_lift_r, tr_roll_r, tr_pitch_r, tr_yaw_r;
  logic signed [7:0] tr_lift_nxt, tr_roll_nxt, tr_pitch_nxt, tr_yaw_nxt;
  logic [7:0]        joy_roll_r, joy_pitch_r, joy_yaw_r, joy_lift_r;
  logic [7:0]        joy_roll_nxt, joy_pitch_nxt, joy_yaw_nxt, joy_lift_nxt;
  logic signed [7:0] ax_roll_r, ax_yaw_r, ax_roll_nxt, ax_yaw_nxt;
  logic signed [9:0] ax_pitch_r, ax_pitch_nxt;
  logic [7:0]        ax_lift_r, ax_lift_nxt;
  logic signed [8:0] mot1_r, mot2_r, mot3_r, mot4_r;
  logic signed [8:0] mot1_nxt, mot2_nxt, mot3_nxt, mot4_nxt;

  logic              adv;
  logic              recomp;
  logic              axes_zero, is_exit, is_switch, key_ok;
  logic signed [9:0] sum_roll, sum_yaw, sum_lift;
  logic signed [11:0] e_roll2, e_pitch2, e_yaw, e_lift;

  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;
  assign recomp   = !exit_r && (mode_r == qmm_pkg::MODE_MANUAL);

  assign axes_zero = (ax_roll_r == '0) && (ax_pitch_r == '0) &&
                     (ax_yaw_r == '0) && (ax_lift_r == '0);
  assign is_exit   = (s1_key_r == exit_key_r);
  assign is_switch = (s1_key_r == switch_key_r);

  always_comb begin
    mode_nxt      = mode_r;
    exit_nxt      = exit_r;
    tr_lift_nxt   = tr_lift_r;
    tr_roll_nxt   = tr_roll_r;
    tr_pitch_nxt  = tr_pitch_r;
    tr_yaw_nxt    = tr_yaw_r;
    joy_roll_nxt  = joy_roll_r;
    joy_pitch_nxt = joy_pitch_r;
    joy_yaw_nxt   = joy_yaw_r;
    joy_lift_nxt  = joy_lift_r;
    key_ok        = !is_switch || axes_zero;

    if (!exit_r && mode_r == qmm_pkg::MODE_SAFE) begin
      if (s1_cmd_r == qmm_pkg::CMD_KEY) begin
        // exit test wins when both key codes match
        if (is_exit) begin
          if (axes_zero) exit_nxt = 1'b1;
        end else if (is_switch && axes_zero) begin
          mode_nxt = qmm_pkg::MODE_MANUAL;
        end
      end
    end else if (!exit_r && mode_r == qmm_pkg::MODE_MANUAL) begin
      if (s1_cmd_r == qmm_pkg::CMD_KEY) begin
        if (key_ok) begin
          if (s1_key_r inside {[qmm_pkg::KEY_MODE_LO:qmm_pkg::KEY_MODE_HI]}) begin
            mode_nxt = qmm_pkg::mode_t'(s1_key_r[2:0]);
          end else begin
            case (s1_key_r)
              qmm_pkg::KEY_LIFT_UP:  tr_lift_nxt  = qmm_pkg::trim_up(tr_lift_r);
              qmm_pkg::KEY_LIFT_DN:  tr_lift_nxt  = qmm_pkg::trim_dn(tr_lift_r);
              qmm_pkg::KEY_ROLL_UP:  tr_roll_nxt  = qmm_pkg::trim_up(tr_roll_r);
              qmm_pkg::KEY_ROLL_DN:  tr_roll_nxt  = qmm_pkg::trim_dn(tr_roll_r);
              qmm_pkg::KEY_PITCH_UP: tr_pitch_nxt = qmm_pkg::trim_up(tr_pitch_r);
              qmm_pkg::KEY_PITCH_DN: tr_pitch_nxt = qmm_pkg::trim_dn(tr_pitch_r);
              qmm_pkg::KEY_YAW_UP:   tr_yaw_nxt   = qmm_pkg::trim_up(tr_yaw_r);
              qmm_pkg::KEY_YAW_DN:   tr_yaw_nxt   = qmm_pkg::trim_dn(tr_yaw_r);
              default: ;
            endcase
          end
        end
      end else begin
        joy_roll_nxt  = s1_roll_r;
        joy_pitch_nxt = s1_pitch_r;
        joy_yaw_nxt   = s1_yaw_r;
        joy_lift_nxt  = s1_lift_r;
      end
    end
  end

  // Recompute the combined axes from the updated trims and stick values.
  assign sum_roll     = {{2{tr_roll_nxt[7]}}, tr_roll_nxt} + $signed({2'b00, joy_roll_nxt});
  assign ax_pitch_nxt = {{2{tr_pitch_nxt[7]}}, tr_pitch_nxt} +
                        $signed({2'b00, joy_pitch_nxt});
  assign sum_yaw      = {{2{tr_yaw_nxt[7]}}, tr_yaw_nxt} + $signed({2'b00, joy_yaw_nxt});
  assign sum_lift     = {{2{tr_lift_nxt[7]}}, tr_lift_nxt} + $signed({2'b00, joy_lift_nxt});

  always_comb begin
    if (sum_roll > qmm_pkg::RP_MAX)      ax_roll_nxt = qmm_pkg::RP_MAX[7:0];
    else if (sum_roll < qmm_pkg::RP_MIN) ax_roll_nxt = qmm_pkg::RP_MIN[7:0];
    else                                 ax_roll_nxt = sum_roll[7:0];

    if (sum_yaw > qmm_pkg::RP_MAX)       ax_yaw_nxt = qmm_pkg::RP_MAX[7:0];
    else if (sum_yaw < qmm_pkg::RP_MIN)  ax_yaw_nxt = qmm_pkg::RP_MIN[7:0];
    else                                 ax_yaw_nxt = sum_yaw[7:0];

    if (sum_lift > qmm_pkg::LIFT_MAX)      ax_lift_nxt = qmm_pkg::LIFT_MAX[7:0];
    else if (sum_lift < qmm_pkg::LIFT_MIN) ax_lift_nxt = qmm_pkg::LIFT_MIN[7:0];
    else                                   ax_lift_nxt = sum_lift[7:0];
  end

  // X-configuration mix
  assign e_roll2  = {{3{ax_roll_nxt[7]}}, ax_roll_nxt, 1'b0};
  assign e_pitch2 = {ax_pitch_nxt[9], ax_pitch_nxt, 1'b0};
  assign e_yaw    = {{4{ax_yaw_nxt[7]}}, ax_yaw_nxt};
  assign e_lift   = $signed({4'b0000, ax_lift_nxt});

  assign mot1_nxt = qmm_pkg::div4_trunc(e_lift + e_pitch2 - e_yaw);
  assign mot2_nxt = qmm_pkg::div4_trunc(e_lift - e_roll2 + e_yaw);
  assign mot3_nxt = qmm_pkg::div4_trunc(e_lift - e_pitch2 - e_yaw);
  assign mot4_nxt = qmm_pkg::div4_trunc(e_lift + e_roll2 + e_yaw);

  // payload of the input stage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r   <= in_cmd;
      s1_key_r   <= in_key_code;
      s1_roll_r  <= in_stick_roll;
      s1_pitch_r <= in_stick_pitch;
      s1_yaw_r   <= in_stick_yaw;
      s1_lift_r  <= in_stick_lift;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk) begin
    if (adv) begin
      out_mode_r <= mode_nxt;
      out_exit_r <= exit_nxt;
      out_m1_r   <= recomp ? mot1_nxt : mot1_r;
      out_m2_r   <= recomp ? mot2_nxt : mot2_r;
      out_m3_r   <= recomp ? mot3_nxt : mot3_r;
      out_m4_r   <= recomp ? mot4_nxt : mot4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_key_r   <= qmm_pkg::EXIT_KEY_RST;
      switch_key_r <= qmm_pkg::SWITCH_KEY_RST;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      mode_r       <= qmm_pkg::MODE_SAFE;
      exit_r       <= 1'b0;
      tr_lift_r    <= '0;
      tr_roll_r    <= '0;
      tr_pitch_r   <= '0;
      tr_yaw_r     <= '0;
      joy_roll_r   <= '0;
      joy_pitch_r  <= '0;
      joy_yaw_r    <= '0;
      joy_lift_r   <= '0;
      ax_roll_r    <= '0;
      ax_pitch_r   <= '0;
      ax_yaw_r     <= '0;
      ax_lift_r    <= '0;
      mot1_r       <= '0;
      mot2_r       <= '0;
      mot3_r       <= '0;
      mot4_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == qmm_pkg::CFG_EXIT_KEY) exit_key_r <= cfg_wdata;
        else                                    switch_key_r <= cfg_wdata;
      end
      if (in_ready) s1_v_r <= in_valid;
      if (adv)            out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
      if (adv) begin
        mode_r       <= mode_nxt;
        exit_r       <= exit_nxt;
        tr_lift_r    <= tr_lift_nxt;
        tr_roll_r    <= tr_roll_nxt;
        tr_pitch_r   <= tr_pitch_nxt;
        tr_yaw_r     <= tr_yaw_nxt;
        joy_roll_r   <= joy_roll_nxt;
        joy_pitch_r  <= joy_pitch_nxt;
        joy_yaw_r    <= joy_yaw_nxt;
        joy_lift_r   <= joy_lift_nxt;
        // combined axes and motors move only on a manual-mode word
        if (recomp) begin
          ax_roll_r  <= ax_roll_nxt;
          ax_pitch_r <= ax_pitch_nxt;
          ax_yaw_r   <= ax_yaw_nxt;
          ax_lift_r  <= ax_lift_nxt;
          mot1_r     <= mot1_nxt;
          mot2_r     <= mot2_nxt;
          mot3_r     <= mot3_nxt;
          mot4_r     <= mot4_nxt;
        end
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_flight_mode = out_mode_r;
  assign out_exit_done   = out_exit_r;
  assign out_motor_one   = out_m1_r;
  assign out_motor_two   = out_m2_r;
  assign out_motor_three = out_m3_r;
  assign out_motor_four  = out_m4_r;

  `ASSERT_NEXT(a_exit_sticky, exit_r, exit_r)
  `ASSERT_NEXT(a_exit_freezes_mode, exit_r, $stable(mode_r))
  `ASSERT_NEXT(a_state_moves_on_word, !adv, $stable(mode_r) && $stable(ax_pitch_r))
  `ASSERT_IMPLY(a_lift_in_range, 1'b1, ax_lift_r <= qmm_pkg::LIFT_MAX[7:0])
  `ASSERT_IMPLY(a_full_blocks_input, s1_v_r && out_v_r && !out_ready, !in_ready)

endmodule
